### design/ppd_pkg.sv
// ----------------------------------------------------------------------------
// ppd_pkg: shared widths and types for the point/plane distance pipeline
// Holds the datapath widths of every stage and the control struct that
// travels beside the data through the front end, divider and square root.
// ----------------------------------------------------------------------------
package ppd_pkg;

  // coordinates and difference vectors
  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int AXES    = 3;
  localparam int PTS     = 4;

  // cross product
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int N_W     = PROD_W + 1;
  localparam int NMAG_W  = N_W - 1;
  localparam int HALF_W  = NMAG_W / 2;
  localparam int NH_W    = N_W - HALF_W;
  localparam int PH_W    = NH_W + DIFF_W;

  // dot products
  localparam int T_W     = PH_W + HALF_W + 1;
  localparam int S_W     = T_W + 1;
  localparam int SMAG_W  = S_W - 2;
  localparam int NN_W    = 2 * NMAG_W;

  // squaring of |s| in chunks
  localparam int CHUNK_W = SMAG_W / 4;
  localparam int CPROD_W = 2 * CHUNK_W;
  localparam int NCHUNK  = 4;
  localparam int NPROD   = 10;
  localparam int SS_W    = 2 * SMAG_W;

  // divider and square root
  localparam int Q_W     = 2 * DIFF_W;
  localparam int ROOT_W  = Q_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int DIST_W  = COORD_W + 1;

  // stream widths
  localparam int IN_TDATA_W  = PTS * AXES * COORD_W;
  localparam int OUT_TDATA_W = ((DIST_W + 1 + 7) / 8) * 8;

  // flags that ride along with each request
  typedef struct packed {
    logic valid;
    logic above;
    logic degenerate;
  } ppd_ctl_t;

endpackage

### design/ppd_front.sv
// ----------------------------------------------------------------------------
// ppd_front: normal, offset and squared terms
// Ten register stages: edge vectors, cross product, dot products with the
// normal, magnitude of the offset and its square. Emits s*s and max(n.n, 1).
// ----------------------------------------------------------------------------
module ppd_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [ppd_pkg::IN_TDATA_W-1:0]    in_data,
  output ppd_pkg::ppd_ctl_t                 ctl_out,
  output logic [ppd_pkg::SS_W-1:0]          ss_out,
  output logic [ppd_pkg::NN_W-1:0]          dv_out
);
  import ppd_pkg::*;

  // valid chain for the stages before the flags are known
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  ppd_ctl_t c7_r, c8_r, c9_r, c10_r;

  // stage 1: edge vectors
  logic signed [DIFF_W-1:0] u_r [AXES], v_r [AXES], w_r [AXES];
  logic signed [DIFF_W-1:0] u_nxt [AXES], v_nxt [AXES], w_nxt [AXES];

  always_comb begin
    logic signed [COORD_W-1:0] pa, pb, pc, pq;
    for (int k = 0; k < AXES; k++) begin
      pa = in_data[(0 * AXES + k) * COORD_W +: COORD_W];
      pb = in_data[(1 * AXES + k) * COORD_W +: COORD_W];
      pc = in_data[(2 * AXES + k) * COORD_W +: COORD_W];
      pq = in_data[(3 * AXES + k) * COORD_W +: COORD_W];
      u_nxt[k] = DIFF_W'(pb) - DIFF_W'(pa);
      v_nxt[k] = DIFF_W'(pc) - DIFF_W'(pa);
      w_nxt[k] = DIFF_W'(pq) - DIFF_W'(pa);
    end
  end

  // stage 2: cross product terms
  logic signed [PROD_W-1:0] p_r [2 * AXES];
  logic signed [DIFF_W-1:0] w2_r [AXES];

  // stage 3: normal and its magnitude
  logic signed [N_W-1:0]    n_r [AXES];
  logic [NMAG_W-1:0]        m_r [AXES];
  logic signed [DIFF_W-1:0] w3_r [AXES];
  logic signed [N_W-1:0]    n_nxt [AXES];
  logic [NMAG_W-1:0]        m_nxt [AXES];

  always_comb begin
    logic signed [N_W-1:0] neg;
    for (int k = 0; k < AXES; k++) begin
      n_nxt[k] = N_W'(p_r[2 * k]) - N_W'(p_r[2 * k + 1]);
      neg      = -n_nxt[k];
      m_nxt[k] = n_nxt[k][N_W-1] ? neg[NMAG_W-1:0] : n_nxt[k][NMAG_W-1:0];
    end
  end

  // stage 4: partial products of n.w and n.n
  logic signed [PH_W-1:0]   ph_r [AXES], pl_r [AXES];
  logic [2*HALF_W-1:0]      hh_r [AXES], hl_r [AXES], ll_r [AXES];
  logic signed [PH_W-1:0]   ph_nxt [AXES], pl_nxt [AXES];

  always_comb begin
    logic signed [NH_W-1:0] nh;
    logic signed [HALF_W:0] nl;
    for (int k = 0; k < AXES; k++) begin
      nh        = n_r[k][N_W-1:HALF_W];
      nl        = {1'b0, n_r[k][HALF_W-1:0]};
      ph_nxt[k] = nh * w3_r[k];
      pl_nxt[k] = nl * w3_r[k];
    end
  end

  // stage 5: per-axis products reassembled
  logic signed [T_W-1:0] t_r [AXES];
  logic [NN_W-1:0]       sq_r [AXES];

  // stage 6: sums over the axes
  logic signed [S_W-1:0] s_r;
  logic [NN_W-1:0]       nn6_r;

  // stage 7: magnitude of the offset
  logic [SMAG_W-1:0]     smag_r;
  logic [NN_W-1:0]       nn7_r;
  logic signed [S_W-1:0] sneg;
  assign sneg = -s_r;

  // stage 8: chunk products of |s| squared
  logic [CPROD_W-1:0]    pp_r [NPROD];
  logic [NN_W-1:0]       nn8_r;
  logic [CHUNK_W-1:0]    ch [NCHUNK];

  always_comb begin
    for (int i = 0; i < NCHUNK; i++) ch[i] = smag_r[i * CHUNK_W +: CHUNK_W];
  end

  // stage 9: two partial sums of s*s
  logic [SS_W-1:0]       x_r, y_r;
  logic [NN_W-1:0]       nn9_r;

  // stage 10: s*s and the divisor
  logic [SS_W-1:0]       ss_r;
  logic [NN_W-1:0]       dv_r;

  // valid and flag chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      c7_r  <= '0;
      c8_r  <= '0;
      c9_r  <= '0;
      c10_r <= '0;
    end else if (en) begin
      v1_r  <= in_valid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      c7_r.valid      <= v6_r;
      c7_r.above      <= !s_r[S_W-1] && (s_r != '0);
      c7_r.degenerate <= (nn6_r == '0);
      c8_r  <= c7_r;
      c9_r  <= c8_r;
      c10_r <= c9_r;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < AXES; k++) begin
        u_r[k]  <= u_nxt[k];
        v_r[k]  <= v_nxt[k];
        w_r[k]  <= w_nxt[k];
        w2_r[k] <= w_r[k];
        w3_r[k] <= w2_r[k];
        n_r[k]  <= n_nxt[k];
        m_r[k]  <= m_nxt[k];
        ph_r[k] <= ph_nxt[k];
        pl_r[k] <= pl_nxt[k];
        hh_r[k] <= m_r[k][NMAG_W-1:HALF_W] * m_r[k][NMAG_W-1:HALF_W];
        hl_r[k] <= m_r[k][NMAG_W-1:HALF_W] * m_r[k][HALF_W-1:0];
        ll_r[k] <= m_r[k][HALF_W-1:0] * m_r[k][HALF_W-1:0];
        t_r[k]  <= (T_W'(ph_r[k]) <<< HALF_W) + T_W'(pl_r[k]);
        sq_r[k] <= (NN_W'(hh_r[k]) << (2 * HALF_W)) + (NN_W'(hl_r[k]) << (HALF_W + 1))
                   + NN_W'(ll_r[k]);
      end
      p_r[0] <= u_r[1] * v_r[2];
      p_r[1] <= u_r[2] * v_r[1];
      p_r[2] <= u_r[2] * v_r[0];
      p_r[3] <= u_r[0] * v_r[2];
      p_r[4] <= u_r[0] * v_r[1];
      p_r[5] <= u_r[1] * v_r[0];
      s_r    <= S_W'(t_r[0]) + S_W'(t_r[1]) + S_W'(t_r[2]);
      nn6_r  <= sq_r[0] + sq_r[1] + sq_r[2];
      smag_r <= s_r[S_W-1] ? sneg[SMAG_W-1:0] : s_r[SMAG_W-1:0];
      nn7_r  <= nn6_r;
      pp_r[0] <= ch[0] * ch[0];
      pp_r[1] <= ch[1] * ch[1];
      pp_r[2] <= ch[2] * ch[2];
      pp_r[3] <= ch[3] * ch[3];
      pp_r[4] <= ch[0] * ch[1];
      pp_r[5] <= ch[0] * ch[2];
      pp_r[6] <= ch[0] * ch[3];
      pp_r[7] <= ch[1] * ch[2];
      pp_r[8] <= ch[1] * ch[3];
      pp_r[9] <= ch[2] * ch[3];
      nn8_r  <= nn7_r;
      x_r    <= {pp_r[3], pp_r[2], pp_r[1], pp_r[0]}
                + (SS_W'(pp_r[4]) << (CHUNK_W + 1))
                + (SS_W'(pp_r[5]) << (2 * CHUNK_W + 1));
      y_r    <= (SS_W'(pp_r[6]) << (3 * CHUNK_W + 1))
                + (SS_W'(pp_r[7]) << (3 * CHUNK_W + 1))
                + (SS_W'(pp_r[8]) << (4 * CHUNK_W + 1))
                + (SS_W'(pp_r[9]) << (5 * CHUNK_W + 1));
      nn9_r  <= nn8_r;
      ss_r   <= x_r + y_r;
      dv_r   <= (nn9_r == '0) ? NN_W'(1) : nn9_r;
    end
  end

  assign ctl_out = c10_r;
  assign ss_out  = ss_r;
  assign dv_out  = dv_r;

endmodule

### design/ppd_div.sv
// ----------------------------------------------------------------------------
// ppd_div: pipelined restoring divider
// One quotient bit per stage: floor(s*s / n.n), which is below 2^Q_W
// because the distance never exceeds the query's distance to A.
// ----------------------------------------------------------------------------
module ppd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  ppd_pkg::ppd_ctl_t             ctl_in,
  input  logic [ppd_pkg::SS_W-1:0]      ss_in,
  input  logic [ppd_pkg::NN_W-1:0]      dv_in,
  output ppd_pkg::ppd_ctl_t             ctl_out,
  output logic [ppd_pkg::Q_W-1:0]       q_out
);
  import ppd_pkg::*;

  logic [NN_W-1:0] rem_src [Q_W];
  logic [Q_W-1:0]  lo_src  [Q_W];
  logic [NN_W-1:0] dv_src  [Q_W];
  ppd_ctl_t        ctl_src [Q_W];

  logic [NN_W-1:0] rem_r [Q_W];
  logic [Q_W-1:0]  lo_r  [Q_W];
  logic [NN_W-1:0] dv_r  [Q_W-1];
  ppd_ctl_t        ctl_r [Q_W];

  assign rem_src[0] = ss_in[Q_W+NN_W-1:Q_W];
  assign lo_src[0]  = ss_in[Q_W-1:0];
  assign dv_src[0]  = dv_in;
  assign ctl_src[0] = ctl_in;

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [NN_W:0] trial, diff;
    logic          ge;

    // shift in the next dividend bit and try a subtract
    assign trial = {rem_src[k], lo_src[k][Q_W-1]};
    assign diff  = trial - {1'b0, dv_src[k]};
    assign ge    = trial >= {1'b0, dv_src[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else if (en) begin
        ctl_r[k] <= ctl_src[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[NN_W-1:0] : trial[NN_W-1:0];
        lo_r[k]  <= {lo_src[k][Q_W-2:0], ge};
      end
    end

    if (k < Q_W - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          dv_r[k] <= dv_src[k];
        end
      end
      assign rem_src[k+1] = rem_r[k];
      assign lo_src[k+1]  = lo_r[k];
      assign dv_src[k+1]  = dv_r[k];
      assign ctl_src[k+1] = ctl_r[k];
    end
  end

  assign ctl_out = ctl_r[Q_W-1];
  assign q_out   = lo_r[Q_W-1];

endmodule

### design/ppd_sqrt.sv
// ----------------------------------------------------------------------------
// ppd_sqrt: pipelined integer square root
// One root bit per stage, digit by digit, floor of the square root.
// ----------------------------------------------------------------------------
module ppd_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  ppd_pkg::ppd_ctl_t             ctl_in,
  input  logic [ppd_pkg::Q_W-1:0]       q_in,
  output ppd_pkg::ppd_ctl_t             ctl_out,
  output logic [ppd_pkg::ROOT_W-1:0]    root_out
);
  import ppd_pkg::*;

  logic [REM_W-1:0]  rem_src  [ROOT_W];
  logic [ROOT_W-1:0] root_src [ROOT_W];
  logic [Q_W-1:0]    x_src    [ROOT_W];
  ppd_ctl_t          ctl_src  [ROOT_W];

  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [Q_W-1:0]    x_r    [ROOT_W-1];
  ppd_ctl_t          ctl_r  [ROOT_W];

  assign rem_src[0]  = '0;
  assign root_src[0] = '0;
  assign x_src[0]    = q_in;
  assign ctl_src[0]  = ctl_in;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W+1:0] t, trial, diff;
    logic             ge;

    // bring down two bits, compare against 4*root+1
    assign t     = {rem_src[k], x_src[k][Q_W-1:Q_W-2]};
    assign trial = {2'b00, root_src[k], 2'b01};
    assign diff  = t - trial;
    assign ge    = t >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else if (en) begin
        ctl_r[k] <= ctl_src[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[REM_W-1:0] : t[REM_W-1:0];
        root_r[k] <= {root_src[k][ROOT_W-2:0], ge};
      end
    end

    if (k < ROOT_W - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[k] <= {x_src[k][Q_W-3:0], 2'b00};
        end
      end
      assign rem_src[k+1]  = rem_r[k];
      assign root_src[k+1] = root_r[k];
      assign x_src[k+1]    = x_r[k];
      assign ctl_src[k+1]  = ctl_r[k];
    end
  end

  assign ctl_out  = ctl_r[ROOT_W-1];
  assign root_out = root_r[ROOT_W-1];

endmodule

### design/point_plane_distance_side.sv
// ----------------------------------------------------------------------------
// point_plane_distance_side: distance of a point to a plane and its side
// Streams plane points A, B, C and a query point, returns floor distance.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  channel: one request carries A, B, C and the query point, twelve
//         signed Q16.16 coordinates. Accepted when in_tvalid and in_tready.
//   out_* channel: one result per request, in order: distance (Q17.16,
//         truncated), the above flag in tdata, degenerate in tuser.
//   From accept to out_tvalid a request passes 10 front-end stages
//   (edges, cross product, dot products, squaring), 66 divider stages at
//   one quotient bit each, 33 square-root stages and the output register.
//   Throughput is one request per cycle, with no bubbles, unless stalled.
//   Collinear plane points give degenerate = 1 with distance and above 0.
//   Reset empties the pipeline and drops out_tvalid; no other state.
//   A stall on out_tready with a result in the output register freezes the
//   whole pipeline; it stays until taken and in_tready drops in that cycle.
// ----------------------------------------------------------------------------
module point_plane_distance_side (
  input  logic                                clk,
  input  logic                                rst_n,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, query_x, query_y, query_z
  input  logic [ppd_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // distance[32:0], above[33], zero fill
  output logic [ppd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // degenerate
  output logic                                out_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready
);
  import ppd_pkg::*;

  logic                  en;
  ppd_ctl_t              fr_ctl, dv_ctl, sq_ctl;
  logic [SS_W-1:0]       fr_ss;
  logic [NN_W-1:0]       fr_dv;
  logic [Q_W-1:0]        dv_q;
  logic [ROOT_W-1:0]     sq_root;

  logic                  out_vld_r;
  logic [DIST_W-1:0]     out_dist_r;
  logic                  out_above_r;
  logic                  out_deg_r;

  // the pipeline moves whenever the output register can take a result
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  ppd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_data  (in_tdata),
    .ctl_out  (fr_ctl),
    .ss_out   (fr_ss),
    .dv_out   (fr_dv)
  );

  ppd_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_in  (fr_ctl),
    .ss_in   (fr_ss),
    .dv_in   (fr_dv),
    .ctl_out (dv_ctl),
    .q_out   (dv_q)
  );

  ppd_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .ctl_in   (dv_ctl),
    .q_in     (dv_q),
    .ctl_out  (sq_ctl),
    .root_out (sq_root)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= sq_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dist_r  <= sq_ctl.degenerate ? '0 : DIST_W'(sq_root);
      out_above_r <= sq_ctl.above;
      out_deg_r   <= sq_ctl.degenerate;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OUT_TDATA_W - DIST_W - 1)'(0), out_above_r, out_dist_r};
  assign out_tuser  = out_deg_r;

  // a collinear plane gives a zero result with no side
  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[DIST_W:0] == '0))
    else $error("degenerate result carries nonzero distance or side");

  // a held result stalls the input side
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while output is stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

### bench/point_plane_distance_side_tb.sv
// ----------------------------------------------------------------------------
// point_plane_distance_side_tb: self-checking bench for the plane distance
// Drives plane points and query points through the stream input with random
// gaps, stalls the result side at random, and compares every result with an
// exact wide-integer prediction of distance, side flag and degenerate flag.
// ----------------------------------------------------------------------------
module point_plane_distance_side_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppd_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 200;

  typedef logic signed [255:0] wide_t;
  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              above;
    logic              degenerate;
  } dist_result_t;

  logic                   clk;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tvalid;
  logic                   out_tready;

  dist_result_t expected_q[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  bit           quiet;

  point_plane_distance_side DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tdata(in_tdata),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  // clock, 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // exact distance, side and degenerate flag for one request
  function automatic dist_result_t plane_distance(input coord_t c[12]);
    wide_t pt[4][3];
    wide_t u[3], v[3], w[3], n[3];
    wide_t s, nn, ss, cand, prod;
    dist_result_t r;
    logic [DIST_W-1:0] q;
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 3; k++)
        pt[i][k] = wide_t'($signed(c[i*3+k]));
    for (int k = 0; k < 3; k++) begin
      u[k] = pt[1][k] - pt[0][k];
      v[k] = pt[2][k] - pt[0][k];
      w[k] = pt[3][k] - pt[0][k];
    end
    n[0] = u[1] * v[2] - u[2] * v[1];
    n[1] = u[2] * v[0] - u[0] * v[2];
    n[2] = u[0] * v[1] - u[1] * v[0];
    s  = n[0] * w[0] + n[1] * w[1] + n[2] * w[2];
    nn = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
    ss = s * s;
    q = '0;
    r.degenerate = (nn == 0);
    r.above = (s > 0);
    // bitwise floor search of sqrt(ss / nn)
    if (!r.degenerate) begin
      for (int i = DIST_W - 1; i >= 0; i--) begin
        cand = '0;
        cand[DIST_W-1:0] = q | (33'd1 << i);
        prod = cand * cand * nn;
        if (prod <= ss) q = cand[DIST_W-1:0];
      end
    end
    r.distance = q;
    return r;
  endfunction

  // send one request, then an optional gap
  task automatic send_point(input coord_t c[12]);
    int gap;
    logic [IN_TDATA_W-1:0] data;
    for (int i = 0; i < 12; i++)
      data[i*COORD_W +: COORD_W] = c[i];
    in_tdata  <= data;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_q = {expected_q, plane_distance(c)};
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic coord_t rand_coord(input int mode);
    case (mode)
      0: return $urandom;
      1: return coord_t'($signed($urandom_range(0, 2000)) - 1000);
      2: return coord_t'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    endcase
  endfunction

  // fill a request; shape picks collinear or on-plane cases
  task automatic make_random(output coord_t c[12], input int shape);
    int mode;
    int k1;
    int src;
    mode = $urandom_range(0, 9) < 5 ? 0 : $urandom_range(1, 3);
    for (int i = 0; i < 12; i++) c[i] = rand_coord(mode);
    k1 = $signed($urandom_range(0, 6)) - 3;
    src = $urandom_range(0, 2);
    case (shape)
      1: for (int k = 0; k < 3; k++)
           c[6+k] = c[k] + coord_t'(k1 * $signed(c[3+k] - c[k]));
      2: for (int k = 0; k < 3; k++) c[9+k] = c[src*3 + k];
      3: for (int k = 0; k < 3; k++) c[9+k] = c[k] + (c[3+k] - c[k]) + (c[6+k] - c[k]);
      default: ;
    endcase
  endtask

  task automatic test_extremes();
    coord_t c[12];
    coord_t vals[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
    for (int j = 0; j < 8; j++) begin
      for (int i = 0; i < 12; i++) c[i] = vals[(i + j * 3 + i / 3) % 4];
      send_point(c);
    end
    // axis-aligned unit plane z = 0 with query above and below
    c = '{0, 0, 0, 32'h1_0000, 0, 0, 0, 32'h1_0000, 0, 0, 0, 32'h7fff_ffff};
    send_point(c);
    c[11] = 32'h8000_0000;
    send_point(c);
    c[11] = 32'h0000_0001;
    send_point(c);
    // widest triangle, query in far corner
    c = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    send_point(c);
  endtask

  task automatic test_collinear();
    coord_t c[12];
    c = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h1234_5678, 32'h8765_4321, 32'h7fff_ffff};
    send_point(c);
    for (int j = 0; j < 5; j++) begin
      make_random(c, 1);
      send_point(c);
    end
  endtask

  task automatic test_on_plane();
    coord_t c[12];
    for (int j = 0; j < 5; j++) begin
      make_random(c, 2 + (j % 2));
      send_point(c);
    end
  endtask

  task automatic test_random(input int count);
    coord_t c[12];
    int pick;
    for (int j = 0; j < count; j++) begin
      pick = $urandom_range(0, 9);
      make_random(c, pick == 0 ? 1 : pick == 1 ? 2 : pick == 2 ? 3 : 0);
      send_point(c);
    end
  endtask

  // hold off until the pipeline has handed back everything
  task automatic test_drain_pause();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // result side stall bursts
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each result with the oldest prediction
  always @(posedge clk) begin
    dist_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with no request pending, actual %h/%b", $time,
                 out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_tdata[DIST_W-1:0] !== exp_r.distance) begin
          $display("%0t: distance expected %h actual %h", $time, exp_r.distance,
                   out_tdata[DIST_W-1:0]);
          mismatch_count++;
        end
        if (out_tdata[DIST_W] !== exp_r.above) begin
          $display("%0t: above expected %b actual %b", $time, exp_r.above,
                   out_tdata[DIST_W]);
          mismatch_count++;
        end
        if (out_tuser !== exp_r.degenerate) begin
          $display("%0t: degenerate expected %b actual %b", $time, exp_r.degenerate,
                   out_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    quiet = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_collinear();
    test_on_plane();
    test_drain_pause();
    test_random(1300);
    test_drain_pause();
    quiet = 1'b1;
    test_random(330);
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
